// ===== rtl/lsau_pkg.sv =====
// ----------------------------------------------------------------------------
// lsau_pkg
// Types and codes of the load/store address unit: transaction payloads,
// memory operation codes, error codes and the pending load state.
// ----------------------------------------------------------------------------
package lsau_pkg;

	localparam logic [3:0] REG_PC = 4'd15;
	localparam logic [31:0] PC_STORE_OFFSET = 32'd4;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_READ  = 2'd1,
		MEM_WRITE = 2'd2
	} lsau_mem_op_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_WB_PC  = 2'd1,
		ERR_RM_PC  = 2'd2,
		ERR_BIT4   = 2'd3
	} lsau_error_t;

	typedef enum logic [1:0] {
		SHIFT_LSL = 2'd0,
		SHIFT_LSR = 2'd1,
		SHIFT_ASR = 2'd2,
		SHIFT_ROR = 2'd3
	} lsau_shift_t;

	typedef enum logic {
		KIND_INSTR  = 1'b0,
		KIND_RETURN = 1'b1
	} lsau_kind_t;

	typedef struct packed {
		lsau_kind_t  kind;
		logic [31:0] instruction;
		logic [31:0] base_value;
		logic [31:0] offset_reg_value;
		logic [31:0] store_value;
		logic        carry_in;
		logic [31:0] read_data;
	} lsau_in_t;

	typedef struct packed {
		lsau_mem_op_t mem_op;
		logic         mem_byte;
		logic [31:0]  mem_address;
		logic [31:0]  mem_write_data;
		logic         reg_write;
		logic [3:0]   reg_index;
		logic [31:0]  reg_value;
		lsau_error_t  error;
	} lsau_out_t;

	typedef struct packed {
		logic [1:0] rotate;
		logic       byte_load;
		logic [3:0] dest;
	} lsau_pend_t;

endpackage

// ===== rtl/lsau_shifter.sv =====
// ----------------------------------------------------------------------------
// lsau_shifter
// Barrel shifter for the register offset: LSL, LSR, ASR and ROR, with the
// zero-amount forms (LSR/ASR by 32, RRX with carry).
// ----------------------------------------------------------------------------
module lsau_shifter (
	input  logic [31:0]         value,
	input  lsau_pkg::lsau_shift_t shift_op,
	input  logic [4:0]          amount,
	input  logic                carry_in,
	output logic [31:0]         result
);
	import lsau_pkg::*;

	logic [31:0] sign_fill;
	logic [63:0] ror_word;

	assign sign_fill = {32{value[31]}};
	assign ror_word = {value, value} >> amount;

	always_comb begin
		case (shift_op)
			SHIFT_LSL: result = value << amount;
			SHIFT_LSR: result = (amount == 5'd0) ? 32'd0 : (value >> amount);
			SHIFT_ASR: result = (amount == 5'd0) ? sign_fill
				: 32'($signed(value) >>> amount);
			SHIFT_ROR: result = (amount == 5'd0) ? {carry_in, value[31:1]}
				: ror_word[31:0];
			default: result = value;
		endcase
	end

endmodule

// ===== rtl/lsau_exec.sv =====
// ----------------------------------------------------------------------------
// lsau_exec
// Single-pass execute logic: decodes a transfer instruction into its memory
// request and base writeback, or an error code, or aligns returned load data,
// and computes the next pending load state.
// ----------------------------------------------------------------------------
module lsau_exec (
	input  lsau_pkg::lsau_in_t   item,
	input  lsau_pkg::lsau_pend_t pend,
	output lsau_pkg::lsau_out_t  result,
	output lsau_pkg::lsau_pend_t pend_next
);
	import lsau_pkg::*;

	logic        reg_off;
	logic        pre;
	logic        up;
	logic        bytef;
	logic        wb;
	logic        load;
	logic [3:0]  rn;
	logic [3:0]  rd;
	logic [11:0] field;
	logic [31:0] shifted;
	logic [31:0] off;
	logic [31:0] final_addr;
	logic [31:0] addr;
	logic [63:0] rot_word;
	lsau_error_t err;

	assign reg_off = item.instruction[25];
	assign pre     = item.instruction[24];
	assign up      = item.instruction[23];
	assign bytef   = item.instruction[22];
	assign wb      = item.instruction[21] | ~pre;
	assign load    = item.instruction[20];
	assign rn      = item.instruction[19:16];
	assign rd      = item.instruction[15:12];
	assign field   = item.instruction[11:0];

	lsau_shifter u_shifter (
		.value    (item.offset_reg_value),
		.shift_op (lsau_shift_t'(field[6:5])),
		.amount   (field[11:7]),
		.carry_in (item.carry_in),
		.result   (shifted)
	);

	assign off = reg_off ? shifted : {20'd0, field};
	assign final_addr = up ? (item.base_value + off) : (item.base_value - off);
	assign addr = pre ? final_addr : item.base_value;
	assign rot_word = {item.read_data, item.read_data} >> {pend.rotate, 3'b000};

	always_comb begin
		if (wb && rn == REG_PC) begin
			err = ERR_WB_PC;
		end else if (reg_off && field[3:0] == REG_PC) begin
			err = ERR_RM_PC;
		end else if (reg_off && field[4]) begin
			err = ERR_BIT4;
		end else begin
			err = ERR_NONE;
		end
	end

	always_comb begin
		result = '0;
		result.mem_op = MEM_NONE;
		result.error = ERR_NONE;
		pend_next = pend;
		if (item.kind == KIND_RETURN) begin
			result.reg_write = 1'b1;
			result.reg_index = pend.dest;
			result.reg_value = pend.byte_load ? {24'd0, item.read_data[7:0]}
				: rot_word[31:0];
		end else if (err != ERR_NONE) begin
			result.error = err;
		end else begin
			result.mem_byte = bytef;
			result.mem_address = addr;
			if (load) begin
				result.mem_op = MEM_READ;
				pend_next.rotate = addr[1:0];
				pend_next.byte_load = bytef;
				pend_next.dest = rd;
			end else begin
				result.mem_op = MEM_WRITE;
				result.mem_write_data = (rd == REG_PC)
					? (item.store_value + PC_STORE_OFFSET) : item.store_value;
			end
			if (wb && (!load || rd != rn)) begin
				result.reg_write = 1'b1;
				result.reg_index = rn;
				result.reg_value = final_addr;
			end
		end
	end

endmodule

// ===== rtl/load_store_address_unit_core.sv =====
// ----------------------------------------------------------------------------
// load_store_address_unit_core
// Single-data-transfer address unit: word/byte load and store requests with
// base writeback, and alignment of returned load data.
// ----------------------------------------------------------------------------
// The unit takes one transaction per cycle unless stalled, an instruction or
// a returned load datum, and gives exactly one result for each: the
// transaction waits in the input register, then the execute logic (offset
// shifter and one 32-bit add/subtract) fills the result register. The result
// register holds a finished result while the next transaction is accepted;
// the input side stalls only when both registers are full and the output is
// stalled. A load return uses the alignment and destination of the most
// recent error-free load ahead of it in transaction order.
// ----------------------------------------------------------------------------
module load_store_address_unit_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lsau_pkg::lsau_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lsau_pkg::lsau_out_t out_data
);
	import lsau_pkg::*;

	logic       valid_s1;
	lsau_in_t   item_s1;
	logic       valid_s2;
	lsau_out_t  result_s2;
	lsau_pend_t pend_q;
	lsau_pend_t pend_next;
	lsau_out_t  result;
	logic       adv_s2;
	logic       adv_s1;

	assign adv_s2 = ~valid_s2 | out_ready;
	assign adv_s1 = valid_s1 & adv_s2;
	assign in_ready = ~valid_s1 | adv_s2;

	lsau_exec u_exec (
		.item      (item_s1),
		.pend      (pend_q),
		.result    (result),
		.pend_next (pend_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pend_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				pend_q <= pend_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = result_s2;

`ifndef NO_ASSERTIONS
	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error != ERR_NONE
		|-> out_data.mem_op == MEM_NONE && !out_data.reg_write)
		else $error("error transaction carries a request or writeback");

	a_pend_change: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(pend_q))
		else $error("pending load state changed without a transaction");

	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the result register is empty");

	a_return_writes: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.kind == KIND_RETURN
		|=> out_valid && out_data.reg_write && out_data.reg_index == $past(pend_q.dest))
		else $error("load return lost its destination write");
`endif

endmodule
